// ===== sv/pireg_pkg.sv =====
// pireg_pkg: shared types and constants for the pi regulator
// register map, configuration record and accumulator limits; no dependencies

package pireg_pkg;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_REFERENCE      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_KP_GAIN        = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_KI_GAIN        = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_LOWER_LIMIT    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_UPPER_LIMIT    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_INTEGRAL_SHIFT = 3'd5;

    // reset values
    localparam logic signed [15:0] RST_REFERENCE      = 16'sd0;
    localparam logic [14:0]        RST_KP_GAIN        = 15'd200;
    localparam logic [14:0]        RST_KI_GAIN        = 15'd2000;
    localparam logic signed [15:0] RST_LOWER_LIMIT    = -16'sd6900;
    localparam logic signed [15:0] RST_UPPER_LIMIT    = 16'sd6900;
    localparam logic [3:0]         RST_INTEGRAL_SHIFT = 4'd12;

    // smallest integral divisor exponent
    localparam logic [3:0] MIN_INTEGRAL_SHIFT = 4'd12;

    // accumulator saturates symmetrically at +/-(2^31-1)
    localparam logic signed [32:0] ACC_MAX = 33'sh0_7FFF_FFFF;
    localparam logic signed [32:0] ACC_MIN = -33'sh0_7FFF_FFFF;

    typedef struct packed {
        logic signed [15:0] reference;
        logic [14:0]        kp_gain;
        logic [14:0]        ki_gain;
        logic signed [15:0] lower_limit;
        logic signed [15:0] upper_limit;
        logic [3:0]         integral_shift;
    } t_cfg;

endpackage

// ===== sv/pireg_cfg.sv =====
// pireg_cfg: configuration register file of the pi regulator
// depends on pireg_pkg for the register map and the t_cfg record

module pireg_cfg (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_wr_en,
    input  logic [pireg_pkg::CFG_ADDR_W-1:0]      i_wr_addr,
    input  logic [pireg_pkg::CFG_DATA_W-1:0]      i_wr_data,
    output pireg_pkg::t_cfg                       o_cfg
);

    pireg_pkg::t_cfg r_cfg;
    pireg_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            case (i_wr_addr)
                pireg_pkg::REG_REFERENCE:      n_cfg.reference      = $signed(i_wr_data);
                pireg_pkg::REG_KP_GAIN:        n_cfg.kp_gain        = i_wr_data[14:0];
                pireg_pkg::REG_KI_GAIN:        n_cfg.ki_gain        = i_wr_data[14:0];
                pireg_pkg::REG_LOWER_LIMIT:    n_cfg.lower_limit    = $signed(i_wr_data);
                pireg_pkg::REG_UPPER_LIMIT:    n_cfg.upper_limit    = $signed(i_wr_data);
                pireg_pkg::REG_INTEGRAL_SHIFT: n_cfg.integral_shift = i_wr_data[3:0];
                default:                       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reference      <= pireg_pkg::RST_REFERENCE;
            r_cfg.kp_gain        <= pireg_pkg::RST_KP_GAIN;
            r_cfg.ki_gain        <= pireg_pkg::RST_KI_GAIN;
            r_cfg.lower_limit    <= pireg_pkg::RST_LOWER_LIMIT;
            r_cfg.upper_limit    <= pireg_pkg::RST_UPPER_LIMIT;
            r_cfg.integral_shift <= pireg_pkg::RST_INTEGRAL_SHIFT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/pi_regulator_saturating.sv =====
// pi_regulator_saturating: top level of the saturating pi regulator
// depends on pireg_pkg and pireg_cfg
//
// Usage
//   s_axis carries one signed 16-bit measured sample per transfer; m_axis
//   returns one signed 16-bit drive value per sample, in order. The cfg
//   channel writes registers 0..5 (reference, kp, ki, lower and upper
//   limit, integral shift); o_cfg_ready is always high and writes to other
//   indexes are dropped. Write configuration only while no sample is in
//   flight.
//   Four register stages: input, gain products, integral update, output.
//   m_axis_tvalid rises once the sample has passed the input, product,
//   integral and output registers; one sample per cycle is sustained while
//   the receiver accepts, the integral accumulator being the only loop and
//   closing in one add and saturate per cycle.
//   Each stage has its own valid bit and moves forward whenever the stage
//   ahead is empty or moving, so a stalled receiver only holds items back
//   once all four stages are full; s_axis_tready then drops.
//   Synchronous reset empties the pipeline, clears the accumulator and loads
//   the register defaults.

module pi_regulator_saturating #(
    parameter int unsigned PROP_SHIFT = 12
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pireg_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [pireg_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    // sample stream in
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [15:0]                        s_axis_tdata,   // [15:0] measured
    // drive stream out
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [15:0]                        m_axis_tdata    // [15:0] drive
);

    localparam logic signed [32:0] PROP_BIAS = (33'sd1 <<< PROP_SHIFT) - 33'sd1;

    pireg_pkg::t_cfg w_cfg;

    assign o_cfg_ready = 1'b1;

    pireg_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (i_cfg_valid),
        .i_wr_addr (i_cfg_addr),
        .i_wr_data (i_cfg_wdata),
        .o_cfg     (w_cfg)
    );

    // stage valids
    logic r_v_in, r_v_prod, r_v_int, r_v_out;
    logic w_rdy_in, w_rdy_prod, w_rdy_int, w_rdy_out;

    assign w_rdy_out  = !r_v_out  || m_axis_tready;
    assign w_rdy_int  = !r_v_int  || w_rdy_out;
    assign w_rdy_prod = !r_v_prod || w_rdy_int;
    assign w_rdy_in   = !r_v_in   || w_rdy_prod;
    assign s_axis_tready = w_rdy_in;

    // payload
    logic signed [15:0] r_meas;
    logic signed [31:0] r_prop_p;
    logic signed [31:0] r_iprod;
    logic signed [31:0] r_prop_c;
    logic signed [31:0] r_int;
    logic [15:0]        r_drive;

    logic signed [31:0] n_int;
    logic [15:0]        n_drive;

    // error and both gain products
    logic signed [16:0] w_err;
    logic signed [32:0] w_prop_full;
    logic signed [32:0] w_iprod_full;

    always_comb begin
        w_err        = 17'(w_cfg.reference) - 17'(r_meas);
        w_prop_full  = w_err * $signed({1'b0, w_cfg.kp_gain});
        w_iprod_full = w_err * $signed({1'b0, w_cfg.ki_gain});
    end

    // saturating integral update; a zero ki gain clears the accumulator
    logic signed [32:0] w_acc_sum;

    always_comb begin
        w_acc_sum = 33'(r_int) + 33'(r_iprod);
        if (w_cfg.ki_gain == 15'd0) begin
            n_int = 32'sd0;
        end else if (w_acc_sum > pireg_pkg::ACC_MAX) begin
            n_int = pireg_pkg::ACC_MAX[31:0];
        end else if (w_acc_sum < pireg_pkg::ACC_MIN) begin
            n_int = pireg_pkg::ACC_MIN[31:0];
        end else begin
            n_int = w_acc_sum[31:0];
        end
    end

    // truncating scale-down, sum and clamp
    logic [3:0]         w_shift;
    logic signed [32:0] w_int_bias;
    logic signed [32:0] w_prop_q;
    logic signed [32:0] w_int_q;
    logic signed [33:0] w_y;

    always_comb begin
        w_shift = (w_cfg.integral_shift < pireg_pkg::MIN_INTEGRAL_SHIFT)
                ? pireg_pkg::MIN_INTEGRAL_SHIFT : w_cfg.integral_shift;
        w_int_bias = (33'sd1 <<< w_shift) - 33'sd1;
        // round toward zero: bias negative values before the arithmetic shift
        w_prop_q = (33'(r_prop_c) + (r_prop_c[31] ? PROP_BIAS : 33'sd0)) >>> PROP_SHIFT;
        w_int_q  = (33'(r_int) + (r_int[31] ? w_int_bias : 33'sd0)) >>> w_shift;
        w_y      = 34'(w_prop_q) + 34'(w_int_q);
        if (w_y > 34'(w_cfg.upper_limit)) begin
            n_drive = w_cfg.upper_limit;
        end else if (w_y < 34'(w_cfg.lower_limit)) begin
            n_drive = w_cfg.lower_limit;
        end else begin
            n_drive = w_y[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_in   <= 1'b0;
            r_v_prod <= 1'b0;
            r_v_int  <= 1'b0;
            r_v_out  <= 1'b0;
            r_int    <= 32'sd0;
        end else begin
            if (w_rdy_in) begin
                r_v_in <= s_axis_tvalid;
            end
            if (w_rdy_prod) begin
                r_v_prod <= r_v_in;
            end
            if (w_rdy_int) begin
                r_v_int <= r_v_prod;
                if (r_v_prod) begin
                    r_int <= n_int;
                end
            end
            if (w_rdy_out) begin
                r_v_out <= r_v_int;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_in && s_axis_tvalid) begin
            r_meas <= $signed(s_axis_tdata);
        end
        if (w_rdy_prod && r_v_in) begin
            r_prop_p <= w_prop_full[31:0];
            r_iprod  <= w_iprod_full[31:0];
        end
        if (w_rdy_int && r_v_prod) begin
            r_prop_c <= r_prop_p;
        end
        if (w_rdy_out && r_v_int) begin
            r_drive <= n_drive;
        end
    end

    assign m_axis_tvalid = r_v_out;
    assign m_axis_tdata  = r_drive;

endmodule

// ===== sv/pireg_checker.sv =====
// pireg_checker: port-level checks for pi_regulator_saturating, with its bind
// depends on pireg_pkg; shadows the limit registers from the cfg channel

module pireg_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    input  logic                               o_cfg_ready,
    input  logic [pireg_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [pireg_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    input  logic [15:0]                        s_axis_tdata,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic [15:0]                        m_axis_tdata
);

    logic signed [15:0] r_lower;
    logic signed [15:0] r_upper;
    logic [2:0]         r_inflight;
    logic               w_in_xfer;
    logic               w_out_xfer;

    assign w_in_xfer  = s_axis_tvalid && s_axis_tready;
    assign w_out_xfer = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower    <= pireg_pkg::RST_LOWER_LIMIT;
            r_upper    <= pireg_pkg::RST_UPPER_LIMIT;
            r_inflight <= 3'd0;
        end else begin
            if (i_cfg_valid && o_cfg_ready && i_cfg_addr == pireg_pkg::REG_LOWER_LIMIT) begin
                r_lower <= $signed(i_cfg_wdata);
            end
            if (i_cfg_valid && o_cfg_ready && i_cfg_addr == pireg_pkg::REG_UPPER_LIMIT) begin
                r_upper <= $signed(i_cfg_wdata);
            end
            r_inflight <= r_inflight + 3'(w_in_xfer) - 3'(w_out_xfer);
        end
    end

    // a stalled result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("drive changed while stalled");

    // no result without a sample behind it
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_inflight != 3'd0)
        else $error("result with no sample in flight");

    // four stages hold at most four samples
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= 3'd4)
        else $error("more samples in flight than stages");

    // drive stays inside ordered limits
    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_lower <= r_upper |->
            $signed(m_axis_tdata) >= r_lower && $signed(m_axis_tdata) <= r_upper)
        else $error("drive outside limits");

endmodule

bind pi_regulator_saturating pireg_checker u_pireg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cfg_valid   (i_cfg_valid),
    .o_cfg_ready   (o_cfg_ready),
    .i_cfg_addr    (i_cfg_addr),
    .i_cfg_wdata   (i_cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
